>>> design/battery_voltage_supervisor_defines.svh
// assertion macros used by the supervisor top level
`ifndef BATTERY_VOLTAGE_SUPERVISOR_DEFINES_SVH
`define BATTERY_VOLTAGE_SUPERVISOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define BVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/bvs_pkg.sv
// types and constants of the battery voltage supervisor
`timescale 1ns / 1ps
package bvs_pkg;

  localparam int MV_W  = 14;
  localparam int RUN_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [MV_W-1:0]  MV_MAX  = {MV_W{1'b1}};
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_EN = 2'd3;

  localparam logic [MV_W-1:0]  CUTOFF_RST  = 14'd3400;
  localparam logic [MV_W-1:0]  WARN_RST    = 14'd3500;
  localparam logic [RUN_W-1:0] CONFIRM_RST = 8'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_WALK,
    ST_DIV,
    ST_DECIDE
  } state_t;

endpackage

>>> design/battery_voltage_supervisor.sv
// top level of the battery voltage supervisor: sequencer, ring walk and decision
//
// Each request carries a battery sample and a charger flag and yields one result with the
// trimmed or plain mean of the sample ring and the power-off and warning flags. The block
// takes one request at a time: in_tready is high only while the sequencer is idle. A request
// passes through the ring write, a walk of the n stored samples through the registered read
// port of the ring memory, a wait on the one-bit-per-cycle divider for the SUM_W-bit quotient
// while the ring is not yet full (SUM_W = 14 + log2(RING_DEPTH), 18 by default; no divide
// once the ring is full), and the decision. The result waits in an output register, so a new
// request is taken while the last result has not yet been collected; the decision stalls only
// while that register is still occupied. Reset clears the fill count at once, so no clearing
// pass is needed.
`timescale 1ns / 1ps
`include "battery_voltage_supervisor_defines.svh"
module battery_voltage_supervisor #(
  parameter int RING_DEPTH = 16,
  parameter int FULL_SHIFT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample_mv[13:0], zero pad
  input  logic        in_tuser,   // charger_present
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // average_mv[13:0], zero pad
  output logic [2:0]  out_tuser,  // power_off, warn_start, low_battery
  input  logic        cfg_we,
  input  logic [bvs_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bvs_pkg::MV_W-1:0]      cfg_wdata
);

  localparam int MV_W  = bvs_pkg::MV_W;
  localparam int RUN_W = bvs_pkg::RUN_W;
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = MV_W + IDX_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

  bvs_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [MV_W-1:0]  lo_r, lo_nxt;
  logic [MV_W-1:0]  hi_r, hi_nxt;
  logic [MV_W-1:0]  sample_r, sample_nxt;
  logic             charger_r, charger_nxt;
  logic [MV_W-1:0]  avg_r, avg_nxt;

  logic [RUN_W-1:0] cut_run_r, cut_run_nxt;
  logic [RUN_W-1:0] warn_run_r, warn_run_nxt;
  logic             warn_active_r, warn_active_nxt;

  logic [MV_W-1:0]  cut_thr_r, cut_thr_nxt;
  logic [MV_W-1:0]  warn_thr_r, warn_thr_nxt;
  logic [RUN_W-1:0] confirm_r, confirm_nxt;
  logic             warn_en_r, warn_en_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [MV_W-1:0]  out_avg_r, out_avg_nxt;
  logic             out_off_r, out_off_nxt;
  logic             out_start_r, out_start_nxt;
  logic             out_low_r, out_low_nxt;

  logic             ram_we;
  logic             ram_re;
  logic [MV_W-1:0]  ram_rdata;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;

  logic [SUM_W-1:0] trim_sum;
  logic [SUM_W-1:0] trim_avg;
  logic             out_free;
  logic [RUN_W-1:0] cut_run_new;
  logic [RUN_W-1:0] warn_run_new;
  logic             off;
  logic             warn_ok;

  bvs_ram #(
    .WIDTH (MV_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (sample_r),
    .re    (ram_re),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  bvs_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .numer    (sum_r),
    .denom    (fill_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign trim_sum = sum_r - SUM_W'(lo_r) - SUM_W'(hi_r);
  assign trim_avg = trim_sum >> FULL_SHIFT;
  assign out_free = !out_valid_r || out_tready;

  assign cut_run_new  = (avg_r > cut_thr_r) ? '0 :
                        (cut_run_r == bvs_pkg::RUN_MAX) ? cut_run_r : cut_run_r + 1'b1;
  assign warn_run_new = (avg_r > warn_thr_r) ? '0 :
                        (warn_run_r == bvs_pkg::RUN_MAX) ? warn_run_r : warn_run_r + 1'b1;
  assign off     = (cut_run_new >= confirm_r) && !charger_r;
  assign warn_ok = (warn_run_new >= confirm_r) && !charger_r && warn_en_r;

  always_comb begin
    cut_thr_nxt  = cut_thr_r;
    warn_thr_nxt = warn_thr_r;
    confirm_nxt  = confirm_r;
    warn_en_nxt  = warn_en_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        bvs_pkg::CFG_CUTOFF:  cut_thr_nxt  = cfg_wdata;
        bvs_pkg::CFG_WARN:    warn_thr_nxt = cfg_wdata;
        bvs_pkg::CFG_CONFIRM: confirm_nxt  = cfg_wdata[RUN_W-1:0];
        bvs_pkg::CFG_WARN_EN: warn_en_nxt  = cfg_wdata[0];
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    wr_idx_nxt      = wr_idx_r;
    fill_nxt        = fill_r;
    rd_idx_nxt      = rd_idx_r;
    rd_vld_nxt      = rd_vld_r;
    sum_nxt         = sum_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    sample_nxt      = sample_r;
    charger_nxt     = charger_r;
    avg_nxt         = avg_r;
    cut_run_nxt     = cut_run_r;
    warn_run_nxt    = warn_run_r;
    warn_active_nxt = warn_active_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_avg_nxt     = out_avg_r;
    out_off_nxt     = out_off_r;
    out_start_nxt   = out_start_r;
    out_low_nxt     = out_low_r;
    in_tready       = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    div_start       = 1'b0;

    unique case (state_r)
      bvs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          sample_nxt  = in_tdata[MV_W-1:0];
          charger_nxt = in_tuser;
          state_nxt   = bvs_pkg::ST_WRITE;
        end
      end
      bvs_pkg::ST_WRITE: begin
        ram_we     = 1'b1;
        wr_idx_nxt = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
        fill_nxt   = (fill_r == FULL_CNT) ? fill_r : fill_r + 1'b1;
        rd_idx_nxt = '0;
        rd_vld_nxt = 1'b0;
        sum_nxt    = '0;
        lo_nxt     = bvs_pkg::MV_MAX;
        hi_nxt     = '0;
        state_nxt  = bvs_pkg::ST_WALK;
      end
      bvs_pkg::ST_WALK: begin
        if (rd_idx_r < fill_r) begin
          ram_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
        end
        if (rd_vld_r) begin
          sum_nxt = sum_r + SUM_W'(ram_rdata);
          if (ram_rdata < lo_r) begin
            lo_nxt = ram_rdata;
          end
          if (ram_rdata > hi_r) begin
            hi_nxt = ram_rdata;
          end
        end else if (rd_idx_r == fill_r) begin
          if (fill_r == FULL_CNT) begin
            avg_nxt   = (trim_avg > SUM_W'(bvs_pkg::MV_MAX)) ? bvs_pkg::MV_MAX
                                                             : trim_avg[MV_W-1:0];
            state_nxt = bvs_pkg::ST_DECIDE;
          end else begin
            div_start = 1'b1;
            state_nxt = bvs_pkg::ST_DIV;
          end
        end
      end
      bvs_pkg::ST_DIV: begin
        if (div_done) begin
          avg_nxt   = (div_quo > SUM_W'(bvs_pkg::MV_MAX)) ? bvs_pkg::MV_MAX
                                                          : div_quo[MV_W-1:0];
          state_nxt = bvs_pkg::ST_DECIDE;
        end
      end
      bvs_pkg::ST_DECIDE: begin
        if (out_free) begin
          cut_run_nxt  = cut_run_new;
          warn_run_nxt = warn_run_new;
          if (!off) begin
            warn_active_nxt = warn_ok;
          end
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_r;
          out_off_nxt   = off;
          out_start_nxt = !off && warn_ok && !warn_active_r;
          out_low_nxt   = off ? warn_active_r : warn_ok;
          state_nxt     = bvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bvs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bvs_pkg::ST_IDLE;
      wr_idx_r      <= '0;
      fill_r        <= '0;
      rd_idx_r      <= '0;
      rd_vld_r      <= 1'b0;
      cut_run_r     <= '0;
      warn_run_r    <= '0;
      warn_active_r <= 1'b0;
      cut_thr_r     <= bvs_pkg::CUTOFF_RST;
      warn_thr_r    <= bvs_pkg::WARN_RST;
      confirm_r     <= bvs_pkg::CONFIRM_RST;
      warn_en_r     <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      wr_idx_r      <= wr_idx_nxt;
      fill_r        <= fill_nxt;
      rd_idx_r      <= rd_idx_nxt;
      rd_vld_r      <= rd_vld_nxt;
      cut_run_r     <= cut_run_nxt;
      warn_run_r    <= warn_run_nxt;
      warn_active_r <= warn_active_nxt;
      cut_thr_r     <= cut_thr_nxt;
      warn_thr_r    <= warn_thr_nxt;
      confirm_r     <= confirm_nxt;
      warn_en_r     <= warn_en_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    sum_r       <= sum_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    sample_r    <= sample_nxt;
    charger_r   <= charger_nxt;
    avg_r       <= avg_nxt;
    out_avg_r   <= out_avg_nxt;
    out_off_r   <= out_off_nxt;
    out_start_r <= out_start_nxt;
    out_low_r   <= out_low_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - MV_W){1'b0}}, out_avg_r};
  assign out_tuser  = {out_low_r, out_start_r, out_off_r};

  `BVS_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= FULL_CNT, "fill count beyond ring depth")
  `BVS_ASSERT_NOW(a_div_denom, state_r == bvs_pkg::ST_DIV, fill_r != '0, "divide by empty ring")
  `BVS_ASSERT_NEXT(a_decide_out, state_r == bvs_pkg::ST_DECIDE && out_free,
                   out_tvalid && state_r == bvs_pkg::ST_IDLE, "decision did not post a result")
  `BVS_ASSERT_NOW(a_start_flags, out_tvalid && out_tuser[1],
                  out_tuser[2] && !out_tuser[0], "warning start without low flag or with power-off")

endmodule

>>> design/bvs_ram.sv
// generic ram, one write port and one registered read port
`timescale 1ns / 1ps
module bvs_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/bvs_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bvs_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(NUM_W - 1);
      rem_nxt  = '0;
      quo_nxt  = numer;
      den_nxt  = denom;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt  = {quo_r[NUM_W-2:0], ge};
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
